>>> rtl/core/assert_macros.svh
// Assertion helper macros for the matrix stack core.
// Used by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, reset-gated
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

>>> rtl/core/mste_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the matrix stack transform engine.
// No dependencies.
package mste_pkg;
    localparam int STACK_LEVELS_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAT_WORDS        = 16;
    localparam int MAT_DIM          = 4;

    typedef enum logic [3:0] {
        OP_SELECT   = 4'd0,
        OP_PUSH     = 4'd1,
        OP_POP      = 4'd2,
        OP_IDENTITY = 4'd3,
        OP_WR_OPND  = 4'd4,
        OP_MULT     = 4'd5,
        OP_XLATE    = 4'd6,
        OP_SCALE    = 4'd7,
        OP_READ     = 4'd8
    } t_op;

    // MAC control from the sequencer
    typedef struct packed {
        logic clear;
        logic acc;
    } t_mac_ctl;
endpackage

>>> rtl/core/mste_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate with Q-format rounding and saturation.
// Depends on mste_pkg.
module mste_mac
    import mste_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  t_mac_ctl           i_ctl,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_result
);
    // four 64-bit products need 66 bits exactly
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [65:0] w_rnd;
    logic signed [65:0] w_shf;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + 66'(r_prod);
        end
    end

    assign w_rnd = r_acc + (66'sd1 <<< (FRAC_BITS - 1));
    assign w_shf = w_rnd >>> FRAC_BITS;

    always_comb begin
        if (w_shf > 66'sh7FFFFFFF) begin
            o_result = 32'sh7FFFFFFF;
        end else if (w_shf < -66'sh80000000) begin
            o_result = 32'sh80000000;
        end else begin
            o_result = w_shf[31:0];
        end
    end
endmodule

>>> rtl/core/matrix_stack_transform_engine_top.sv
`timescale 1ns / 1ps
// Select, pop, operand write and refused push go straight to the output state; read, identity,
// push, multiply, translate and scale step through the matrix memory first, the last three
// on the single shared MAC and the one-word-per-cycle memory port.
// One command in flight; input ready only while idle and output empty.
// Synchronous active-low reset: both level-0 matrices read as identity
// (per-stack valid bit on level 0), tops and active stack cleared.
`include "assert_macros.svh"
module matrix_stack_transform_engine_top
    import mste_pkg::*;
#(
    parameter int STACK_LEVELS = STACK_LEVELS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: op[3:0], elem_index[7:4], value_x[39:8], value_y[71:40],
    // value_z[103:72]
    input  logic [103:0] s_axis_tdata,
    // tuser: mode_select
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: read_value[31:0], status[32], active_mode[33], pad to 40
    output logic [39:0]  m_axis_tdata
);
    localparam int LW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
    localparam int AW = LW + 5; // stack bit + level + word
    localparam logic [LW-1:0] LAST = LW'(STACK_LEVELS - 1);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COPY  = 7'b0000010,
        S_IDENT = 7'b0000100,
        S_RDW   = 7'b0001000,
        S_MAC   = 7'b0010000,
        S_WB    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [3:0]  r_op, r_idx;
    logic signed [31:0] r_x, r_y, r_z;
    logic [LW-1:0] r_top [2];
    logic        r_act;
    logic [1:0]  r_base_ok;    // level-0 written since reset
    logic signed [31:0] r_opnd [MAT_WORDS];
    logic signed [31:0] r_res [MAT_WORDS];
    logic [3:0]  r_elem;       // output element / copy word
    logic [2:0]  r_k;          // MAC step 0..7
    logic        r_ovalid;
    logic [31:0] r_rd;
    logic        r_status;

    // matrix memory, registered read
    logic signed [31:0] r_mem [2**AW];
    logic signed [31:0] r_q;
    logic        r_q_base;     // read hit level 0 not yet written
    logic [3:0]  r_q_word;
    logic [AW-1:0] w_raddr, w_waddr;
    logic        w_we;
    logic signed [31:0] w_wd, w_q;

    logic [1:0] w_k2;
    logic signed [31:0] w_b, w_mac;
    t_mac_ctl w_ctl;

    function automatic logic signed [31:0] ident(input logic [3:0] i);
        return (i == 4'd0 || i == 4'd5 || i == 4'd10 || i == 4'd15) ? ONE : 32'sd0;
    endfunction

    assign w_q = r_q_base ? ident(r_q_word) : r_q;
    assign w_k2 = r_k[1:0];

    // read address per state
    always_comb begin
        w_raddr = {r_act, r_top[r_act], r_idx};
        case (r_state)
            S_COPY:  w_raddr = {r_act, r_top[r_act], r_elem};
            S_MAC:   w_raddr = {r_act, r_top[r_act], w_k2, r_elem[1:0]};
            default: w_raddr = {r_act, r_top[r_act], r_idx};
        endcase
    end

    // operand element k for result column elem[3:2]; k taken from the word
    // now on the read data so A and B stay paired
    always_comb begin
        logic [3:0] oi;
        oi = {r_elem[3:2], r_q_word[3:2]};
        case (r_op)
            OP_XLATE: begin
                w_b = ident(oi);
                if (oi == 4'd12) w_b = r_x;
                if (oi == 4'd13) w_b = r_y;
                if (oi == 4'd14) w_b = r_z;
            end
            OP_SCALE: begin
                w_b = ident(oi);
                if (oi == 4'd0)  w_b = r_x;
                if (oi == 4'd5)  w_b = r_y;
                if (oi == 4'd10) w_b = r_z;
            end
            default: w_b = r_opnd[oi];
        endcase
    end

    // r_k: reads k0..3 at 0..3, data 1..4, a/b regs 2..5, products 3..6
    assign w_ctl.clear = (r_state == S_RDW);
    assign w_ctl.acc   = (r_state == S_MAC) && (r_k >= 3'd3) && (r_k <= 3'd6);

    // B must pair with data: delay index by read latency
    logic signed [31:0] r_b;
    logic signed [31:0] r_a;

    mste_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_result(w_mac)
    );

    // write port
    always_comb begin
        w_we = 1'b0;
        w_waddr = {r_act, r_top[r_act], r_elem};
        w_wd = w_q;
        case (r_state)
            S_COPY: begin
                w_we = (r_k == 3'd1);
                w_waddr = {r_act, r_top[r_act] + LW'(1), r_elem};
            end
            S_IDENT: begin
                w_we = 1'b1;
                w_wd = ident(r_elem);
            end
            S_WB: begin
                w_we = 1'b1;
                w_wd = r_res[r_elem];
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wd;
        r_q <= r_mem[w_raddr];
        r_q_word <= w_raddr[3:0];
        r_q_base <= (w_raddr[AW-2:4] == '0) && !r_base_ok[w_raddr[AW-1]];
        r_a <= w_q;
        r_b <= w_b;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_act, r_status, r_rd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top[0] <= '0;
            r_top[1] <= '0;
            r_act <= 1'b0;
            r_base_ok <= 2'b00;
            r_ovalid <= 1'b0;
            r_elem <= '0;
            r_k <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_we && w_waddr[AW-2:4] == '0) r_base_ok[w_waddr[AW-1]] <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op <= s_axis_tdata[3:0];
                        r_idx <= s_axis_tdata[7:4];
                        r_x <= s_axis_tdata[39:8];
                        r_y <= s_axis_tdata[71:40];
                        r_z <= s_axis_tdata[103:72];
                        r_rd <= '0;
                        r_status <= 1'b0;
                        r_elem <= '0;
                        r_k <= '0;
                        case (s_axis_tdata[3:0])
                            OP_SELECT: begin
                                r_act <= s_axis_tuser;
                                r_state <= S_OUT;
                            end
                            OP_PUSH: begin
                                if (r_top[r_act] == LAST) begin
                                    r_status <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_COPY;
                                end
                            end
                            OP_POP: begin
                                if (r_top[r_act] != '0)
                                    r_top[r_act] <= r_top[r_act] - LW'(1);
                                r_state <= S_OUT;
                            end
                            OP_IDENTITY: r_state <= S_IDENT;
                            OP_WR_OPND: begin
                                r_opnd[s_axis_tdata[7:4]] <= s_axis_tdata[39:8];
                                r_state <= S_OUT;
                            end
                            OP_MULT, OP_XLATE, OP_SCALE: r_state <= S_RDW;
                            OP_READ: r_state <= S_RDW;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_COPY: begin
                    // k0: read issued; k1: data valid, write
                    if (r_k == 3'd0) begin
                        r_k <= 3'd1;
                    end else begin
                        r_k <= 3'd0;
                        r_elem <= r_elem + 4'd1;
                        if (r_elem == 4'd15) begin
                            r_top[r_act] <= r_top[r_act] + LW'(1);
                            r_state <= S_OUT;
                        end
                    end
                end
                S_IDENT: begin
                    r_elem <= r_elem + 4'd1;
                    if (r_elem == 4'd15) r_state <= S_OUT;
                end
                S_RDW: begin
                    // read op: address issued at k0, data valid at k1
                    if (r_op == OP_READ) begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd1) begin
                            r_rd <= w_q;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_k <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    // accumulate done at 6, rounded sum read at 7
                    if (r_k == 3'd7) begin
                        r_res[r_elem] <= w_mac;
                        r_k <= '0;
                        r_elem <= r_elem + 4'd1;
                        if (r_elem == 4'd15) begin
                            r_state <= S_WB;
                        end else begin
                            r_state <= S_RDW;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_WB: begin
                    r_elem <= r_elem + 4'd1;
                    if (r_elem == 4'd15) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CHK_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `CHK_NEXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, m_axis_tvalid)
    `CHK_IMPL(a_top_range, i_clk, i_rst_n, 1'b1,
        r_top[0] <= LAST && r_top[1] <= LAST)
endmodule

>>> verif/matrix_stack_transform_engine_top_test.sv
`timescale 1ns / 1ps
// Self-checking test of matrix_stack_transform_engine_top: stack control, operand
// writes, multiply/translate/scale rounding and reads, against an internal predictor.
// Depends on mste_pkg and the engine RTL only.
module matrix_stack_transform_engine_top_test;
    import mste_pkg::*;

    localparam int LEVELS = STACK_LEVELS_DEF;
    localparam int FRAC   = FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] read_value;
        logic               status;
        logic               active_mode;
    } t_cmd_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [39:0]   m_axis_tdata;

    matrix_stack_transform_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] stack_mem [2][LEVELS][MAT_WORDS];
    int unsigned        top_lvl [2];
    logic               act_stack;
    logic signed [31:0] opnd_mat [MAT_WORDS];

    t_cmd_result pending_results[$];
    int  errors = 0;
    int  results_seen = 0;
    int  op_count [16];
    int  full_refusals = 0;
    bit  idle_en = 1'b1;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 results_seen);
    endtask

    function automatic logic signed [31:0] round_dot(longint p0, longint p1,
                                                     longint p2, longint p3);
        logic signed [65:0] acc;
        acc = 66'(p0) + 66'(p1) + 66'(p2) + 66'(p3);
        acc = (acc + (66'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (acc > 66'sd2147483647) return 32'sh7fffffff;
        if (acc < -66'sd2147483648) return 32'sh80000000;
        return acc[31:0];
    endfunction

    task automatic mult_active_top(input logic signed [31:0] m [MAT_WORDS]);
        logic signed [31:0] t [MAT_WORDS];
        longint             p [4];
        int unsigned        lvl;
        lvl = top_lvl[act_stack];
        t = stack_mem[act_stack][lvl];
        for (int i = 0; i < MAT_WORDS; i++) begin
            for (int k = 0; k < 4; k++) begin
                p[k] = longint'(t[(i % 4) + k * 4]) * longint'(m[k + (i / 4) * 4]);
            end
            stack_mem[act_stack][lvl][i] = round_dot(p[0], p[1], p[2], p[3]);
        end
    endtask

    function automatic void load_identity(ref logic signed [31:0] m [MAT_WORDS]);
        for (int i = 0; i < MAT_WORDS; i++) m[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC) : 0;
    endfunction

    // work out the result of one accepted command and update predicted state
    task automatic apply_command(input logic [3:0] op, input logic sel,
                                 input logic [3:0] idx, input logic signed [31:0] x,
                                 input logic signed [31:0] y, input logic signed [31:0] z);
        t_cmd_result        r;
        logic signed [31:0] tmp [MAT_WORDS];
        int unsigned        lvl;
        r.read_value = 0;
        r.status = 1'b0;
        lvl = top_lvl[act_stack];
        op_count[op]++;
        case (op)
            OP_SELECT: act_stack = sel;
            OP_PUSH: begin
                if (lvl >= LEVELS - 1) begin
                    r.status = 1'b1;
                    full_refusals++;
                end else begin
                    stack_mem[act_stack][lvl + 1] = stack_mem[act_stack][lvl];
                    top_lvl[act_stack] = lvl + 1;
                end
            end
            OP_POP: if (lvl > 0) top_lvl[act_stack] = lvl - 1;
            OP_IDENTITY: begin
                load_identity(tmp);
                stack_mem[act_stack][lvl] = tmp;
            end
            OP_WR_OPND: opnd_mat[idx] = x;
            OP_MULT: mult_active_top(opnd_mat);
            OP_XLATE: begin
                load_identity(tmp);
                tmp[12] = x; tmp[13] = y; tmp[14] = z;
                mult_active_top(tmp);
            end
            OP_SCALE: begin
                load_identity(tmp);
                tmp[0] = x; tmp[5] = y; tmp[10] = z;
                mult_active_top(tmp);
            end
            OP_READ: r.read_value = stack_mem[act_stack][lvl][idx];
            default: ;
        endcase
        r.active_mode = act_stack;
        pending_results.push_back(r);
    endtask

    // one command transfer; inputs move on the falling edge
    task automatic send_cmd(input logic [3:0] op, input logic sel = 1'b0,
                            input logic [3:0] idx = 4'd0, input logic [31:0] x = 0,
                            input logic [31:0] y = 0, input logic [31:0] z = 0);
        while (idle_en && $urandom_range(99) < 9) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {z, y, x, idx, op};
        s_axis_tuser  = sel;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_command(op, sel, idx, x, y, z);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(32'h80000)) - 32'h40000;   // about +-4.0
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_cmd_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.read_value)
                    report_mismatch("read_value", m_axis_tdata[31:0], want.read_value);
                if (m_axis_tdata[32] !== want.status)
                    report_mismatch("status", m_axis_tdata[32], want.status);
                if (m_axis_tdata[33] !== want.active_mode)
                    report_mismatch("active_mode", m_axis_tdata[33], want.active_mode);
            end
            results_seen++;
        end
    end

    always @(negedge i_clk) m_axis_tready = !(idle_en && $urandom_range(99) < 9);

    task automatic test_reset_state();
        for (int i = 0; i < MAT_WORDS; i += 5) send_cmd(OP_READ, 0, 4'(i));
        send_cmd(OP_POP);                                   // pop at bottom
        send_cmd(OP_READ, 0, 4'd15);
    endtask

    task automatic test_stack_control();
        send_cmd(OP_SELECT, 1'b1);
        send_cmd(OP_PUSH);
        send_cmd(OP_SCALE, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00020000);
        send_cmd(OP_READ, 0, 4'd0);
        send_cmd(OP_READ, 0, 4'd5);
        send_cmd(OP_POP);
        send_cmd(OP_READ, 0, 4'd0);
        send_cmd(OP_SELECT, 1'b0);
    endtask

    task automatic test_arith();
        // every operand word written before any multiply
        for (int i = 0; i < MAT_WORDS; i++)
            send_cmd(OP_WR_OPND, 0, 4'(i), (i == 15) ? 32'h80000000 : rand_value());
        send_cmd(OP_MULT);
        send_cmd(OP_XLATE, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00018000);
        send_cmd(OP_READ, 0, 4'd12);
        send_cmd(OP_IDENTITY);
        for (int op = 9; op < 16; op++) send_cmd(4'(op), 1'b1, 4'hf, '1, '1, '1);
    endtask

    task automatic test_random(int n_items);
        int  sent;
        logic [3:0] op;
        bit  held;
        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            idle_en = !(sent > n_items / 3 && sent < n_items / 2);
            if ($urandom_range(39) == 0) begin
                // push to the limit, then try more
                for (int i = 0; i < LEVELS + 1; i++) send_cmd(OP_PUSH);
                send_cmd(OP_READ, 0, 4'($urandom));
                sent += LEVELS + 2;
            end else begin
                case ($urandom_range(19))
                    0, 1:     op = OP_SELECT;
                    2, 3:     op = OP_PUSH;
                    4, 5:     op = OP_POP;
                    6:        op = OP_IDENTITY;
                    7, 8, 9:  op = OP_WR_OPND;
                    10:       op = OP_MULT;
                    11, 12:   op = OP_XLATE;
                    13:       op = OP_SCALE;
                    14:       op = 4'($urandom_range(15, 9));
                    default:  op = OP_READ;
                endcase
                send_cmd(op, 1'($urandom), 4'($urandom), rand_value(), rand_value(),
                         rand_value());
                sent++;
            end
            if (!held && sent >= n_items / 2) begin
                wait_drained();                          // sender holds off here
                held = 1'b1;
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        act_stack = 1'b0;
        top_lvl = '{0, 0};
        for (int s = 0; s < 2; s++) load_identity(stack_mem[s][0]);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_stack_control();
        test_arith();
        test_random(920);
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("covered %0d results: %0d multiplies, %0d translates, %0d scales, %0d reads",
                 results_seen, op_count[OP_MULT], op_count[OP_XLATE], op_count[OP_SCALE],
                 op_count[OP_READ]);
        $display("pushes %0d (refused when full %0d), pops %0d, errors %0d",
                 op_count[OP_PUSH], full_refusals, op_count[OP_POP], errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("FAIL");
        $finish;
    end
endmodule
